// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the frame stepper RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// ante implies cons in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// expr never holds
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ----- hw/rtl/ffs_pkg.sv -----
// ---------------------------------------------------------------------------
// ffs_pkg
// Types and constants of the flipbook frame stepper.
// ---------------------------------------------------------------------------
package ffs_pkg;

    localparam int FRAME_W    = 16;
    localparam int TIME_W     = 32;
    localparam int MODE_W     = 2;
    localparam int SPAN_W     = FRAME_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DIV_STEPS  = TIME_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [TIME_W-1:0] LFSR_SEED = 32'hACE1_ACE1;
    localparam logic [TIME_W-1:0] LFSR_TAPS = 32'h8020_0003;

    localparam logic [MODE_W-1:0] MODE_LOOP     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PINGPONG = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RANDOM   = 2'd2;

    localparam logic OP_EMIT   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_START_INDEX  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_INDEX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANIM_MODE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_RANDOM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_EN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_STEP  = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DRAW,
        ST_DRAW_WAIT,
        ST_DIV,
        ST_DIV_WAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic eval;
        logic draw_start;
        logic draw_fin;
        logic div_start;
        logic div_fin;
        logic load_out;
    } ffs_cmd_t;

    typedef struct packed {
        logic need_draw;
        logic need_div;
        logic div_pend;
        logic div_done;
        logic out_free;
    } ffs_status_t;

endpackage

// ----- hw/rtl/ffs_divider.sv -----
// ---------------------------------------------------------------------------
// ffs_divider
// Restoring radix-2 divider, one quotient bit per cycle. Gives quotient
// and remainder; the divisor is never zero in this block.
// ---------------------------------------------------------------------------
module ffs_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ffs_pkg::TIME_W-1:0]  dividend,
    input  logic [ffs_pkg::SPAN_W-1:0]  divisor,
    output logic                        busy,
    output logic                        done,
    output logic [ffs_pkg::TIME_W-1:0]  quotient,
    output logic [ffs_pkg::SPAN_W-1:0]  remainder
);
    import ffs_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] count_reg, count_next;
    logic [TIME_W-1:0]    quo_reg, quo_next;
    logic [SPAN_W-1:0]    rem_reg, rem_next;
    logic [SPAN_W-1:0]    dvs_reg, dvs_next;
    logic [SPAN_W:0]      trial;
    logic [SPAN_W:0]      diff;
    logic                 fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[TIME_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = trial >= {1'b0, dvs_reg};
    end

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            quo_next   = dividend;
            rem_next   = '0;
            dvs_next   = divisor;
        end
        else if (busy_reg)
        begin
            quo_next   = {quo_reg[TIME_W-2:0], fits};
            rem_next   = fits ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];
            count_next = count_reg + DIV_CNT_W'(1);
            if (count_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- hw/rtl/ffs_datapath.sv -----
// ---------------------------------------------------------------------------
// ffs_datapath
// Configuration, item registers, shared step timer, LFSR, frame advance
// logic, divider and output register of the frame stepper.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ffs_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [ffs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ffs_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  ffs_pkg::ffs_cmd_t                cmd,
    output ffs_pkg::ffs_status_t             status,
    input  logic                             operation,
    input  logic                             frame_start,
    input  logic [ffs_pkg::TIME_W-1:0]       delta_time,
    input  logic [ffs_pkg::TIME_W-1:0]       life_time,
    input  logic [ffs_pkg::FRAME_W-1:0]      frame_in,
    input  logic                             going_up_in,
    input  logic [ffs_pkg::TIME_W-1:0]       elapsed_in,
    input  logic [ffs_pkg::TIME_W-1:0]       step_in,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [ffs_pkg::FRAME_W-1:0]      frame_out,
    output logic                             going_up_out,
    output logic [ffs_pkg::TIME_W-1:0]       elapsed_out,
    output logic [ffs_pkg::TIME_W-1:0]       step_out
);
    import ffs_pkg::*;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               up;
    } adv_t;

    // configuration
    logic [FRAME_W-1:0] start_index_reg;
    logic [FRAME_W-1:0] end_index_reg;
    logic [MODE_W-1:0]  anim_mode_reg;
    logic               start_random_reg;
    logic               global_en_reg;
    logic [TIME_W-1:0]  global_step_reg;

    // state
    logic [TIME_W-1:0]  shared_elapsed_reg;
    logic               shared_adv_reg;
    logic [TIME_W-1:0]  lfsr_reg;
    logic               div_pend_reg;
    logic               out_valid_reg;

    // item word
    logic               op_reg;
    logic               fstart_reg;
    logic [TIME_W-1:0]  life_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic               up_reg;
    logic [TIME_W-1:0]  elapsed_reg;
    logic [TIME_W-1:0]  step_reg;
    logic [TIME_W-1:0]  acc_reg;

    logic [FRAME_W-1:0] frame_out_reg;
    logic               up_out_reg;
    logic [TIME_W-1:0]  elapsed_out_reg;
    logic [TIME_W-1:0]  step_out_reg;

    logic [FRAME_W-1:0] eff_end;
    logic [SPAN_W-1:0]  span;
    logic [SPAN_W:0]    pp_span;
    logic [SPAN_W-1:0]  step_divisor;
    logic [TIME_W:0]    acc_sum;
    logic [TIME_W-1:0]  acc_base;
    logic [TIME_W-1:0]  acc_next;
    logic [TIME_W-1:0]  item_diff;
    logic               item_over;
    logic [TIME_W-1:0]  shared_diff;
    logic               shared_over;
    logic               adv;
    adv_t               adv_res;
    logic [FRAME_W-1:0] frame_e;
    logic               up_e;
    logic [TIME_W-1:0]  elapsed_e;
    logic [TIME_W-1:0]  step_e;
    logic               need_draw_c;
    logic               need_div_c;
    logic [TIME_W-1:0]  lfsr_next;
    logic [TIME_W-1:0]  div_dividend;
    logic [SPAN_W-1:0]  div_divisor;
    logic               div_busy;
    logic               div_done;
    logic [TIME_W-1:0]  div_quo;
    logic [SPAN_W-1:0]  div_rem;

    function automatic adv_t advance(input logic [FRAME_W-1:0] f,
                                     input logic               up,
                                     input logic [MODE_W-1:0]  mode,
                                     input logic [FRAME_W-1:0] first,
                                     input logic [FRAME_W-1:0] last);
        adv_t r;
        r.frame = f;
        r.up    = up;
        case (mode)
            MODE_LOOP:
            begin
                r.frame = (f >= last) ? first : f + FRAME_W'(1);
            end
            MODE_PINGPONG:
            begin
                if (up)
                begin
                    if (f >= last)
                    begin
                        r.frame = f - FRAME_W'(1);
                        r.up    = 1'b0;
                    end
                    else
                    begin
                        r.frame = f + FRAME_W'(1);
                    end
                end
                else
                begin
                    if (f <= first)
                    begin
                        r.frame = f + FRAME_W'(1);
                        r.up    = 1'b1;
                    end
                    else
                    begin
                        r.frame = f - FRAME_W'(1);
                    end
                end
            end
            default:
            begin
                r.frame = f;
            end
        endcase
        return r;
    endfunction

    always_comb
    begin
        eff_end      = (end_index_reg < start_index_reg) ? start_index_reg : end_index_reg;
        span         = {1'b0, eff_end} - {1'b0, start_index_reg} + SPAN_W'(1);
        pp_span      = {span, 1'b0} - (SPAN_W + 1)'(1);
        step_divisor = (anim_mode_reg == MODE_LOOP) ? span : pp_span[SPAN_W-1:0];
        lfsr_next    = {1'b0, lfsr_reg[TIME_W-1:1]} ^ (lfsr_reg[0] ? LFSR_TAPS : '0);
        div_dividend = cmd.draw_start ? lfsr_next : life_reg;
        div_divisor  = cmd.draw_start ? span : step_divisor;
    end

    // saturating accumulate at capture
    always_comb
    begin
        acc_base = global_en_reg ? shared_elapsed_reg : elapsed_in;
        acc_sum  = {1'b0, acc_base} + {1'b0, delta_time};
        acc_next = acc_sum[TIME_W] ? '1 : acc_sum[TIME_W-1:0];
    end

    always_comb
    begin
        item_diff   = acc_reg - step_reg;
        item_over   = acc_reg > step_reg;
        shared_diff = acc_reg - global_step_reg;
        shared_over = acc_reg > global_step_reg;
        if (global_en_reg)
        begin
            adv = fstart_reg ? shared_over : shared_adv_reg;
        end
        else
        begin
            adv = item_over;
        end
        adv_res = advance(frame_reg, up_reg, anim_mode_reg, start_index_reg, eff_end);

        if (op_reg == OP_EMIT)
        begin
            frame_e     = start_index_reg;
            up_e        = 1'b1;
            elapsed_e   = '0;
            step_e      = (!global_en_reg && anim_mode_reg == MODE_RANDOM) ? life_reg : step_reg;
            need_draw_c = start_random_reg;
            need_div_c  = !global_en_reg &&
                          (anim_mode_reg == MODE_LOOP || anim_mode_reg == MODE_PINGPONG);
        end
        else
        begin
            frame_e     = adv ? adv_res.frame : frame_reg;
            up_e        = adv ? adv_res.up : up_reg;
            step_e      = step_reg;
            if (global_en_reg)
            begin
                elapsed_e = elapsed_reg;
            end
            else
            begin
                elapsed_e = item_over ? item_diff : acc_reg;
            end
            need_draw_c = adv && (anim_mode_reg == MODE_RANDOM);
            need_div_c  = 1'b0;
        end
    end

    ffs_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.draw_start | cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_index_reg    <= '0;
            end_index_reg      <= '0;
            anim_mode_reg      <= MODE_LOOP;
            start_random_reg   <= 1'b1;
            global_en_reg      <= 1'b0;
            global_step_reg    <= '0;
            shared_elapsed_reg <= '0;
            shared_adv_reg     <= 1'b0;
            lfsr_reg           <= LFSR_SEED;
            div_pend_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_START_INDEX:  start_index_reg  <= cfg_data[FRAME_W-1:0];
                    REG_END_INDEX:    end_index_reg    <= cfg_data[FRAME_W-1:0];
                    REG_ANIM_MODE:    anim_mode_reg    <= cfg_data[MODE_W-1:0];
                    REG_START_RANDOM: start_random_reg <= cfg_data[0];
                    REG_GLOBAL_EN:    global_en_reg    <= cfg_data[0];
                    REG_GLOBAL_STEP:  global_step_reg  <= cfg_data[TIME_W-1:0];
                    default:          ;
                endcase
            end
            if (cmd.eval)
            begin
                div_pend_reg <= need_div_c;
                if (op_reg == OP_UPDATE && global_en_reg && fstart_reg)
                begin
                    shared_elapsed_reg <= shared_over ? shared_diff : acc_reg;
                    shared_adv_reg     <= shared_over;
                end
            end
            if (cmd.draw_start)
            begin
                lfsr_reg <= lfsr_next;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg      <= operation;
            fstart_reg  <= frame_start;
            life_reg    <= life_time;
            frame_reg   <= frame_in;
            up_reg      <= going_up_in;
            elapsed_reg <= elapsed_in;
            step_reg    <= step_in;
            acc_reg     <= acc_next;
        end
        else if (cmd.eval)
        begin
            frame_reg   <= frame_e;
            up_reg      <= up_e;
            elapsed_reg <= elapsed_e;
            step_reg    <= step_e;
        end
        else if (cmd.draw_fin)
        begin
            frame_reg <= start_index_reg + div_rem[FRAME_W-1:0];
        end
        else if (cmd.div_fin)
        begin
            step_reg <= div_quo;
        end
        if (cmd.load_out)
        begin
            frame_out_reg   <= cmd.eval ? frame_e : frame_reg;
            up_out_reg      <= cmd.eval ? up_e : up_reg;
            elapsed_out_reg <= cmd.eval ? elapsed_e : elapsed_reg;
            step_out_reg    <= cmd.eval ? step_e : step_reg;
        end
    end

    always_comb
    begin
        status.need_draw = need_draw_c;
        status.need_div  = need_div_c;
        status.div_pend  = div_pend_reg;
        status.div_done  = div_done;
        status.out_free  = !out_valid_reg || !out_stall;
    end

    assign out_valid    = out_valid_reg;
    assign frame_out    = frame_out_reg;
    assign going_up_out = up_out_reg;
    assign elapsed_out  = elapsed_out_reg;
    assign step_out     = step_out_reg;

    `ASSERT_IMPLIES(a_div_idle_on_start, clk, rst_n, (cmd.draw_start || cmd.div_start), !div_busy)
    `ASSERT_IMPLIES(a_load_into_free_slot, clk, rst_n, cmd.load_out, !(out_valid_reg && out_stall))
    `ASSERT_NEVER(a_lfsr_nonzero, clk, rst_n, lfsr_reg == '0)
    `ASSERT_IMPLIES(a_capture_div_idle, clk, rst_n, cmd.capture, !div_busy && !div_done)

endmodule

// ----- hw/rtl/ffs_ctrl.sv -----
// ---------------------------------------------------------------------------
// ffs_ctrl
// Sequencer of the frame stepper: capture, evaluate, random draw and step
// division on the shared divider, result hand-off.
// ---------------------------------------------------------------------------
module ffs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  ffs_pkg::ffs_status_t  status,
    output ffs_pkg::ffs_cmd_t     cmd
);
    import ffs_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (status.need_draw)
                begin
                    state_next = ST_DRAW;
                end
                else if (status.need_div)
                begin
                    state_next = ST_DIV;
                end
                else if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DRAW:
            begin
                state_next = ST_DRAW_WAIT;
            end
            ST_DRAW_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = status.div_pend ? ST_DIV : ST_FINISH;
                end
            end
            ST_DIV:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            ST_EVAL:
            begin
                cmd.eval     = 1'b1;
                cmd.load_out = !status.need_draw && !status.need_div && status.out_free;
            end
            ST_DRAW:
            begin
                cmd.draw_start = 1'b1;
            end
            ST_DRAW_WAIT:
            begin
                cmd.draw_fin = status.div_done;
            end
            ST_DIV:
            begin
                cmd.div_start = 1'b1;
            end
            ST_DIV_WAIT:
            begin
                cmd.div_fin = status.div_done;
            end
            ST_FINISH:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hw/rtl/flipbook_frame_stepper.sv -----
// ---------------------------------------------------------------------------
// flipbook_frame_stepper
// Steps an item's frame index in loop, up-down or random mode, with
// per-item or shared step timing.
//
//   channel  valid     stall     word
//   in       in_valid  in_stall  operation .. step_in
//   out      out_valid out_stall frame_out .. step_out
//   cfg      cfg_write -         cfg_index, cfg_data
//
// An update is accepted and evaluated, and a random-mode advance draws a
// frame; while the output word is still held it waits in finish until that
// word leaves. The last pass through the shared radix-2 divider leads to
// finish: one pass for a random frame draw, one for the step division of a
// loop or up-down emit; an emit that needs both makes both passes.
// Reset sets configuration defaults, shared timer and LFSR seed at once, no sweep.
// One input word is accepted while an output word is held; the next one waits.
// ---------------------------------------------------------------------------
module flipbook_frame_stepper (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [ffs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ffs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            operation,
    input  logic                            frame_start,
    input  logic [ffs_pkg::TIME_W-1:0]      delta_time,
    input  logic [ffs_pkg::TIME_W-1:0]      life_time,
    input  logic [ffs_pkg::FRAME_W-1:0]     frame_in,
    input  logic                            going_up_in,
    input  logic [ffs_pkg::TIME_W-1:0]      elapsed_in,
    input  logic [ffs_pkg::TIME_W-1:0]      step_in,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ffs_pkg::FRAME_W-1:0]     frame_out,
    output logic                            going_up_out,
    output logic [ffs_pkg::TIME_W-1:0]      elapsed_out,
    output logic [ffs_pkg::TIME_W-1:0]      step_out
);
    import ffs_pkg::*;

    ffs_cmd_t    cmd;
    ffs_status_t status;

    ffs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    ffs_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .operation    (operation),
        .frame_start  (frame_start),
        .delta_time   (delta_time),
        .life_time    (life_time),
        .frame_in     (frame_in),
        .going_up_in  (going_up_in),
        .elapsed_in   (elapsed_in),
        .step_in      (step_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_out    (frame_out),
        .going_up_out (going_up_out),
        .elapsed_out  (elapsed_out),
        .step_out     (step_out)
    );

endmodule
